FILE: rtl/core/srrt_pkg.sv
// shared types and constants for the scrub round-robin table
// no dependencies; imported by srrt_ctrl, srrt_dpath and the top level

package srrt_pkg;

   // fixed field widths of the request and response ports
   localparam int MODE_W   = 3;
   localparam int ID_W     = 8;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 9;

   // ids that the 8-bit id field can name
   localparam int ID_SPACE = 2 ** ID_W;

   // default table sizes
   localparam int DEF_SLOT_COUNT = 256;
   localparam int DEF_ID_COUNT   = 256;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MARK   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_NEXT   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_PICK   = 3'd4;

   // response status codes
   localparam logic [STATUS_W-1:0] STS_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STS_EMPTY   = 3'd1;
   localparam logic [STATUS_W-1:0] STS_PRESENT = 3'd2;
   localparam logic [STATUS_W-1:0] STS_ABSENT  = 3'd3;
   localparam logic [STATUS_W-1:0] STS_FULL    = 3'd4;
   localparam logic [STATUS_W-1:0] STS_RANGE   = 3'd5;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic lookup;
      logic capture;
      logic fetch;
      logic swap_a;
      logic swap_b;
   } srrt_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic go;       // request passed its checks and needs the maps
      logic remove;   // latched operation is a remove
      logic update;   // latched operation is an insert or mark tested
   } srrt_sts_type;

endpackage

FILE: rtl/core/srrt_ram.sv
// generic single-write, single-read ram with registered read data
// depends on nothing

module srrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/srrt_ctrl.sv
// sequencing state machine for the scrub round-robin table
// depends on srrt_pkg; drives commands into srrt_dpath

module srrt_ctrl import srrt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output logic         rsp_valid,
   input  srrt_sts_type sts,
   output srrt_cmd_type cmd
);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_LOOKUP  = 7'b0000010,
      ST_CAPTURE = 7'b0000100,
      ST_FETCH   = 7'b0001000,
      ST_SWAP_A  = 7'b0010000,
      ST_SWAP_B  = 7'b0100000,
      ST_RESPOND = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = sts.go ? ST_LOOKUP : ST_RESPOND;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_CAPTURE;
         end
         ST_CAPTURE: begin
            if (sts.remove) begin
               state_in = ST_FETCH;
            end else if (sts.update) begin
               state_in = ST_SWAP_A;
            end else begin
               state_in = ST_RESPOND;
            end
         end
         ST_FETCH: begin
            state_in = ST_SWAP_A;
         end
         ST_SWAP_A: begin
            state_in = ST_SWAP_B;
         end
         ST_SWAP_B: begin
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.load    = (state_ff == ST_IDLE) && start;
   assign cmd.lookup  = (state_ff == ST_LOOKUP);
   assign cmd.capture = (state_ff == ST_CAPTURE);
   assign cmd.fetch   = (state_ff == ST_FETCH);
   assign cmd.swap_a  = (state_ff == ST_SWAP_A);
   assign cmd.swap_b  = (state_ff == ST_SWAP_B);

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESPOND);

endmodule

FILE: rtl/core/srrt_dpath.sv
// datapath of the scrub round-robin table: slot and id maps, counters, checks
// depends on srrt_pkg and srrt_ram; commanded by srrt_ctrl

module srrt_dpath import srrt_pkg::*; #(
   parameter int SLOT_COUNT = DEF_SLOT_COUNT,
   parameter int ID_COUNT   = DEF_ID_COUNT
) (
   input  logic                clock,
   input  logic                reset,
   input  srrt_cmd_type        cmd,
   output srrt_sts_type        sts,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [ID_W-1:0]     req_entry_id,
   input  logic [ID_W-1:0]     req_pick_index,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ID_W-1:0]     rsp_result_id,
   output logic [COUNT_W-1:0]  rsp_entry_count,
   output logic [COUNT_W-1:0]  rsp_tested_count
);

   localparam int ID_DEPTH = (ID_COUNT < ID_SPACE) ? ID_COUNT : ID_SPACE;
   localparam int ID_AW    = $clog2(ID_DEPTH);
   localparam int SLOT_AW  = $clog2(SLOT_COUNT);
   localparam int CNT_W    = $clog2(SLOT_COUNT + 1);

   // latched request and response
   logic [MODE_W-1:0]   mode_ff;
   logic [ID_AW-1:0]    id_ff;
   logic [SLOT_AW-1:0]  pick_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [ID_W-1:0]     result_ff;

   // values read from the maps
   logic [SLOT_AW-1:0]  slot_ff;   // slot of the requested id
   logic [ID_AW-1:0]    near_ff;   // id read during lookup
   logic [ID_AW-1:0]    far_ff;    // id just below the boundary (remove)

   // table state
   logic [CNT_W-1:0]    held_ff;
   logic [CNT_W-1:0]    held_in;
   logic [CNT_W-1:0]    tested_ff;
   logic [CNT_W-1:0]    tested_in;
   logic [ID_DEPTH-1:0] present_ff;
   logic [ID_DEPTH-1:0] present_in;

   // request checks
   logic [ID_AW-1:0]    id_idx;
   logic                id_oob;
   logic                id_hit;
   logic                is_full;
   logic                is_empty;
   logic                pick_oob;
   logic [STATUS_W-1:0] chk_status;
   logic                chk_go;

   // swap decisions
   logic [CNT_W-1:0]    slot_ext;
   logic                wrap;
   logic                mark_go;
   logic                rem_down;
   logic [SLOT_AW-1:0]  rem_slot;
   logic [SLOT_AW-1:0]  last_slot;
   logic                rem_keep;
   logic [ID_AW-1:0]    ins_id;

   // map ports
   logic                se_we;
   logic [SLOT_AW-1:0]  se_waddr;
   logic [ID_AW-1:0]    se_wdata;
   logic [SLOT_AW-1:0]  se_raddr;
   logic [ID_AW-1:0]    se_rdata;
   logic                es_we;
   logic [ID_AW-1:0]    es_waddr;
   logic [SLOT_AW-1:0]  es_wdata;
   logic [SLOT_AW-1:0]  es_rdata;

   // slot -> id map
   srrt_ram #(
      .WIDTH (ID_AW),
      .DEPTH (SLOT_COUNT)
   ) u_slot_map (
      .clock   (clock),
      .wr_en   (se_we),
      .wr_addr (se_waddr),
      .wr_data (se_wdata),
      .rd_addr (se_raddr),
      .rd_data (se_rdata)
   );

   // id -> slot map
   srrt_ram #(
      .WIDTH (SLOT_AW),
      .DEPTH (ID_DEPTH)
   ) u_id_map (
      .clock   (clock),
      .wr_en   (es_we),
      .wr_addr (es_waddr),
      .wr_data (es_wdata),
      .rd_addr (id_ff),
      .rd_data (es_rdata)
   );

   // checks on the incoming request
   assign id_idx   = req_entry_id[ID_AW-1:0];
   assign id_oob   = 32'(req_entry_id) >= ID_COUNT;
   assign id_hit   = present_ff[id_idx];
   assign is_full  = 32'(held_ff) >= SLOT_COUNT;
   assign is_empty = (held_ff == '0);
   assign pick_oob = 32'(req_pick_index) >= 32'(held_ff);

   always_comb begin
      chk_status = STS_OK;
      chk_go     = 1'b0;
      case (req_mode)
         MODE_INSERT: begin
            if (id_oob) begin
               chk_status = STS_RANGE;
            end else if (id_hit) begin
               chk_status = STS_PRESENT;
            end else if (is_full) begin
               chk_status = STS_FULL;
            end else begin
               chk_go = 1'b1;
            end
         end
         MODE_REMOVE, MODE_MARK: begin
            if (id_oob) begin
               chk_status = STS_RANGE;
            end else if (!id_hit) begin
               chk_status = STS_ABSENT;
            end else begin
               chk_go = 1'b1;
            end
         end
         MODE_NEXT: begin
            if (is_empty) begin
               chk_status = STS_EMPTY;
            end else begin
               chk_go = 1'b1;
            end
         end
         MODE_PICK: begin
            if (is_empty) begin
               chk_status = STS_EMPTY;
            end else if (pick_oob) begin
               chk_status = STS_RANGE;
            end else begin
               chk_go = 1'b1;
            end
         end
         default: begin
            chk_go = 1'b0;
         end
      endcase
   end

   assign sts.go     = chk_go;
   assign sts.remove = (mode_ff == MODE_REMOVE);
   assign sts.update = (mode_ff == MODE_INSERT) || (mode_ff == MODE_MARK);

   // swap decisions from the latched slot and the counters
   assign slot_ext  = CNT_W'(slot_ff);
   assign wrap      = (tested_ff >= held_ff);
   assign mark_go   = (slot_ext >= tested_ff);
   assign rem_down  = (slot_ext < tested_ff);
   assign rem_slot  = rem_down ? SLOT_AW'(tested_ff - 1'b1) : slot_ff;
   assign last_slot = SLOT_AW'(held_ff - 1'b1);
   assign rem_keep  = (rem_slot != last_slot);
   // appended slot equals the boundary: the id swaps with itself
   assign ins_id    = (tested_ff == held_ff) ? id_ff : near_ff;

   // slot map read address
   always_comb begin
      se_raddr = '0;
      if (cmd.lookup) begin
         case (mode_ff)
            MODE_INSERT, MODE_MARK: se_raddr = SLOT_AW'(tested_ff);
            MODE_REMOVE:            se_raddr = last_slot;
            MODE_NEXT:              se_raddr = wrap ? '0 : SLOT_AW'(tested_ff);
            MODE_PICK:              se_raddr = pick_ff;
            default:                se_raddr = '0;
         endcase
      end else if (cmd.capture) begin
         se_raddr = SLOT_AW'(tested_ff - 1'b1);
      end
   end

   // map writes: each swap phase writes one slot and the matching id
   always_comb begin
      se_we    = 1'b0;
      se_waddr = '0;
      se_wdata = '0;
      es_we    = 1'b0;
      es_waddr = '0;
      es_wdata = '0;
      if (cmd.swap_a) begin
         case (mode_ff)
            MODE_INSERT: begin
               se_we    = 1'b1;
               se_waddr = SLOT_AW'(held_ff);
               se_wdata = ins_id;
            end
            MODE_MARK: begin
               se_we    = mark_go;
               se_waddr = slot_ff;
               se_wdata = near_ff;
            end
            MODE_REMOVE: begin
               se_we    = rem_down;
               se_waddr = slot_ff;
               se_wdata = far_ff;
            end
            default: begin
               se_we = 1'b0;
            end
         endcase
         es_we    = se_we;
         es_waddr = se_wdata;
         es_wdata = se_waddr;
      end else if (cmd.swap_b) begin
         case (mode_ff)
            MODE_INSERT: begin
               se_we    = 1'b1;
               se_waddr = SLOT_AW'(tested_ff);
               se_wdata = id_ff;
            end
            MODE_MARK: begin
               se_we    = mark_go;
               se_waddr = SLOT_AW'(tested_ff);
               se_wdata = id_ff;
            end
            MODE_REMOVE: begin
               se_we    = rem_keep;
               se_waddr = rem_slot;
               se_wdata = near_ff;
            end
            default: begin
               se_we = 1'b0;
            end
         endcase
         es_we    = se_we;
         es_waddr = se_wdata;
         es_wdata = se_waddr;
      end
   end

   // counter and presence updates
   always_comb begin
      held_in    = held_ff;
      tested_in  = tested_ff;
      present_in = present_ff;
      if (cmd.capture && (mode_ff == MODE_NEXT) && wrap) begin
         tested_in = '0;
      end
      if (cmd.swap_b) begin
         case (mode_ff)
            MODE_INSERT: begin
               held_in           = held_ff + 1'b1;
               tested_in         = tested_ff + 1'b1;
               present_in[id_ff] = 1'b1;
            end
            MODE_MARK: begin
               if (mark_go) begin
                  tested_in = tested_ff + 1'b1;
               end
            end
            MODE_REMOVE: begin
               held_in           = held_ff - 1'b1;
               present_in[id_ff] = 1'b0;
               if (rem_down) begin
                  tested_in = tested_ff - 1'b1;
               end
            end
            default: begin
               held_in = held_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= '0;
         tested_ff  <= '0;
         present_ff <= '0;
      end else begin
         held_ff    <= held_in;
         tested_ff  <= tested_in;
         present_ff <= present_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff   <= req_mode;
         id_ff     <= id_idx;
         pick_ff   <= SLOT_AW'(req_pick_index);
         status_ff <= chk_status;
         result_ff <= '0;
      end
      if (cmd.capture) begin
         slot_ff <= es_rdata;
         near_ff <= se_rdata;
         if ((mode_ff == MODE_NEXT) || (mode_ff == MODE_PICK)) begin
            result_ff <= ID_W'(se_rdata);
         end
      end
      if (cmd.fetch) begin
         far_ff <= se_rdata;
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_result_id    = result_ff;
   assign rsp_entry_count  = COUNT_W'(held_ff);
   assign rsp_tested_count = COUNT_W'(tested_ff);

   // boundary never passes the end of the held entries
   a_boundary: assert property (@(posedge clock) disable iff (reset)
      tested_ff <= held_ff)
      else $error("tested boundary beyond entry count");

   // a finished remove drops exactly one entry and its presence bit
   a_remove_drop: assert property (@(posedge clock) disable iff (reset)
      (cmd.swap_b && (mode_ff == MODE_REMOVE))
      |=> (held_ff == $past(held_ff) - 1'b1) && !present_ff[$past(id_ff)])
      else $error("remove did not drop its entry");

   // a finished insert leaves the id present and one more entry held
   a_insert_add: assert property (@(posedge clock) disable iff (reset)
      (cmd.swap_b && (mode_ff == MODE_INSERT))
      |=> (held_ff == $past(held_ff) + 1'b1) && present_ff[$past(id_ff)])
      else $error("insert did not add its entry");

endmodule

FILE: rtl/core/scrub_round_robin_table.sv
// top level of the scrub round-robin table
// depends on srrt_pkg, srrt_ctrl, srrt_dpath (which holds two srrt_ram maps)

// One request is taken at a time: a transfer happens on a clock edge with start
// high and busy low, and exactly one response follows, shown for a single cycle
// with rsp_valid high. The receiver cannot stall, so the response must be
// sampled in that cycle. A new request is taken only after the response of the
// previous one. The sequence is set by the two map memories, each with one
// write port and one registered read port: a request addresses the maps in
// a lookup step and takes the read data in a capture step, a remove adds a
// fetch step for its second slot read, and a swap is split into swap_a and
// swap_b because it writes two slots and two ids. A request that fails its
// checks or has an unused mode goes straight to respond. Entry count and
// tested count on the response are the values after the request. The
// presence flags clear at reset; the maps need no clearing.

module scrub_round_robin_table import srrt_pkg::*; #(
   parameter int SLOT_COUNT = DEF_SLOT_COUNT,
   parameter int ID_COUNT   = DEF_ID_COUNT
) (
   input  logic                clock,
   input  logic                reset,

   // request channel
   input  logic                start,
   output logic                busy,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [ID_W-1:0]     req_entry_id,
   input  logic [ID_W-1:0]     req_pick_index,

   // response channel
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ID_W-1:0]     rsp_result_id,
   output logic [COUNT_W-1:0]  rsp_entry_count,
   output logic [COUNT_W-1:0]  rsp_tested_count
);

   srrt_cmd_type cmd;   // sequencing commands
   srrt_sts_type sts;   // request checks and latched operation kind

   // state machine: accept, lookup, capture, optional extra read, optional swap, respond
   srrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   // maps, counters, presence flags and the response registers
   srrt_dpath #(
      .SLOT_COUNT (SLOT_COUNT),
      .ID_COUNT   (ID_COUNT)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_mode         (req_mode),
      .req_entry_id     (req_entry_id),
      .req_pick_index   (req_pick_index),
      .rsp_status       (rsp_status),
      .rsp_result_id    (rsp_result_id),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_tested_count (rsp_tested_count)
   );

   // an accepted request keeps the block busy until its response
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request transfer did not make the block busy");

   // the response strobe is the last busy cycle
   a_rsp_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy && !rsp_valid)
      else $error("block still busy after response");

endmodule

FILE: dv/scrub_round_robin_table_tb.sv
// self-checking testbench for scrub_round_robin_table: directed and random requests,
// responses checked field by field against an in-bench model of the table
// depends on srrt_pkg and the scrub_round_robin_table rtl

module scrub_round_robin_table_tb;
   import srrt_pkg::*;

   localparam int SLOT_COUNT   = DEF_SLOT_COUNT;
   localparam int ID_COUNT     = DEF_ID_COUNT;
   localparam int RANDOM_ITEMS = 1150;
   localparam int QUIET_TAIL   = 120;     // last requests go out back to back
   localparam int DRAIN_CYCLES = 16;      // well above the slowest request, a remove
   localparam int LIMIT_CYCLES = 200000;

   // modes the block ignores
   localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
   localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = 3'd7;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [ID_W-1:0]   entry_id;
      logic [ID_W-1:0]   pick_index;
   } table_op_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     result_id;
      logic [COUNT_W-1:0]  entry_count;
      logic [COUNT_W-1:0]  tested_count;
   } table_rsp_type;

   // every input known from time zero
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic [MODE_W-1:0]   req_mode = MODE_INSERT;
   logic [ID_W-1:0]     req_entry_id = '0;
   logic [ID_W-1:0]     req_pick_index = '0;
   logic                busy;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [ID_W-1:0]     rsp_result_id;
   logic [COUNT_W-1:0]  rsp_entry_count;
   logic [COUNT_W-1:0]  rsp_tested_count;

   scrub_round_robin_table #(
      .SLOT_COUNT(SLOT_COUNT),
      .ID_COUNT  (ID_COUNT)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_entry_id    (req_entry_id),
      .req_pick_index  (req_pick_index),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_result_id   (rsp_result_id),
      .rsp_entry_count (rsp_entry_count),
      .rsp_tested_count(rsp_tested_count)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // ---------------------------------------------------------------------
   // table model: dense slot array, reverse map, presence flags and the
   // boundary between the tested front and the untested back
   // ---------------------------------------------------------------------
   logic [ID_W-1:0] tbl_slot_id [SLOT_COUNT];
   logic [ID_W-1:0] tbl_id_slot [ID_COUNT];
   logic            tbl_present [ID_COUNT];
   int              tbl_held = 0;
   int              tbl_boundary = 0;

   initial begin
      for (int k = 0; k < ID_COUNT; k++) tbl_present[k] = 1'b0;
   end

   // exchange two slots, keeping the reverse map in step
   function automatic void swap_table_slots(int i, int j);
      logic [ID_W-1:0] a, b;
      a = tbl_slot_id[i];
      b = tbl_slot_id[j];
      tbl_id_slot[a] = j[ID_W-1:0];
      tbl_id_slot[b] = i[ID_W-1:0];
      tbl_slot_id[i] = b;
      tbl_slot_id[j] = a;
   endfunction

   // move an untested entry to the boundary and grow the tested part
   function automatic void advance_into_tested(logic [ID_W-1:0] id);
      int s;
      s = tbl_id_slot[id];
      if (s >= tbl_boundary && tbl_boundary < tbl_held) begin
         swap_table_slots(s, tbl_boundary);
         tbl_boundary++;
      end
   endfunction

   function automatic table_rsp_type table_response(table_op_type op);
      table_rsp_type r;
      int            s;
      r.status    = STS_OK;
      r.result_id = '0;
      case (op.mode)
         MODE_INSERT: begin
            if (op.entry_id >= ID_COUNT) r.status = STS_RANGE;
            else if (tbl_present[op.entry_id]) r.status = STS_PRESENT;
            else if (tbl_held >= SLOT_COUNT) r.status = STS_FULL;
            else begin
               tbl_slot_id[tbl_held]       = op.entry_id;
               tbl_id_slot[op.entry_id]    = tbl_held[ID_W-1:0];
               tbl_present[op.entry_id]    = 1'b1;
               tbl_held++;
               advance_into_tested(op.entry_id);
            end
         end
         MODE_REMOVE: begin
            if (op.entry_id >= ID_COUNT) r.status = STS_RANGE;
            else if (!tbl_present[op.entry_id]) r.status = STS_ABSENT;
            else begin
               // step out of the tested part first, then swap with the last slot
               s = tbl_id_slot[op.entry_id];
               if (s < tbl_boundary) begin
                  swap_table_slots(s, tbl_boundary - 1);
                  tbl_boundary--;
               end
               swap_table_slots(tbl_id_slot[op.entry_id], tbl_held - 1);
               tbl_held--;
               tbl_present[op.entry_id] = 1'b0;
            end
         end
         MODE_MARK: begin
            if (op.entry_id >= ID_COUNT) r.status = STS_RANGE;
            else if (!tbl_present[op.entry_id]) r.status = STS_ABSENT;
            else advance_into_tested(op.entry_id);
         end
         MODE_NEXT: begin
            if (tbl_held == 0) r.status = STS_EMPTY;
            else begin
               // all tested: start a new round
               if (tbl_boundary >= tbl_held) tbl_boundary = 0;
               r.result_id = tbl_slot_id[tbl_boundary];
            end
         end
         MODE_PICK: begin
            if (tbl_held == 0) r.status = STS_EMPTY;
            else if (op.pick_index >= tbl_held) r.status = STS_RANGE;
            else r.result_id = tbl_slot_id[op.pick_index];
         end
         default: ;   // unused modes change nothing
      endcase
      r.entry_count  = tbl_held[COUNT_W-1:0];
      r.tested_count = tbl_boundary[COUNT_W-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus generation; a presence map of its own steers the random part
   // toward ids that make it past the checks
   // ---------------------------------------------------------------------
   table_op_type  op_pending [$];
   table_rsp_type rsp_expected [$];
   logic          gen_present [ID_COUNT];
   int            gen_count = 0;
   int            op_total = 0;
   int            rsp_seen = 0;
   int            fail_count = 0;
   int            cycle_count = 0;

   task automatic queue_op(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                           logic [ID_W-1:0] pick);
      table_op_type op;
      op.mode       = mode;
      op.entry_id   = id;
      op.pick_index = pick;
      op_pending    = {op_pending, op};
      if (mode == MODE_INSERT && !gen_present[id] && gen_count < SLOT_COUNT) begin
         gen_present[id] = 1'b1;
         gen_count++;
      end else if (mode == MODE_REMOVE && gen_present[id]) begin
         gen_present[id] = 1'b0;
         gen_count--;
      end
   endtask

   // scan from a random point for an id with the wanted presence
   function automatic logic [ID_W-1:0] find_id(logic want_present);
      int first;
      first = $urandom_range(0, ID_COUNT - 1);
      for (int k = 0; k < ID_COUNT; k++) begin
         if (gen_present[(first + k) % ID_COUNT] == want_present)
            return ID_W'((first + k) % ID_COUNT);
      end
      return first[ID_W-1:0];
   endfunction

   initial begin
      int                roll, counted;
      int                w_ins, w_rem, w_mark, w_next;
      logic [MODE_W-1:0] mode;
      logic [ID_W-1:0]   id, pick;

      for (int k = 0; k < ID_COUNT; k++) gen_present[k] = 1'b0;

      // directed: empty table, absent ids, duplicate insert, pick bounds,
      // round wrap, re-marking a tested id, removal from both parts, unused modes
      queue_op(MODE_NEXT,   8'd0,   8'd0);
      queue_op(MODE_PICK,   8'd0,   8'd0);
      queue_op(MODE_REMOVE, 8'd7,   8'd0);
      queue_op(MODE_MARK,   8'd7,   8'd0);
      queue_op(MODE_INSERT, 8'd0,   8'd255);
      queue_op(MODE_INSERT, 8'd255, 8'd0);
      queue_op(MODE_INSERT, 8'd0,   8'd0);
      queue_op(MODE_INSERT, 8'd170, 8'd0);
      queue_op(MODE_INSERT, 8'd85,  8'd0);
      queue_op(MODE_PICK,   8'd0,   8'd3);
      queue_op(MODE_PICK,   8'd0,   8'd4);
      queue_op(MODE_PICK,   8'd255, 8'd255);
      queue_op(MODE_NEXT,   8'd0,   8'd0);
      queue_op(MODE_MARK,   8'd85,  8'd0);
      queue_op(MODE_MARK,   8'd85,  8'd0);
      queue_op(MODE_NEXT,   8'd0,   8'd0);
      queue_op(MODE_REMOVE, 8'd170, 8'd0);
      queue_op(MODE_REMOVE, 8'd0,   8'd0);
      queue_op(MODE_UNUSED_FIRST,        8'd255, 8'd255);
      queue_op(MODE_UNUSED_FIRST + 3'd1, 8'd85,  8'd170);
      queue_op(MODE_UNUSED_LAST,         8'd170, 8'd85);
      queue_op(MODE_REMOVE, 8'd255, 8'd0);
      queue_op(MODE_REMOVE, 8'd85,  8'd0);
      queue_op(MODE_NEXT,   8'd0,   8'd0);
      queue_op(MODE_INSERT, 8'd1,   8'd0);

      // random: fill to the top, churn while nearly full, drain to empty,
      // then a mixed tail
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         if (counted < 450) begin
            w_ins = 75; w_rem = 5;  w_mark = 8;  w_next = 6;
         end else if (counted < 750) begin
            w_ins = 20; w_rem = 20; w_mark = 25; w_next = 15;
         end else if (counted < 1050) begin
            w_ins = 8;  w_rem = 62; w_mark = 10; w_next = 10;
         end else begin
            w_ins = 20; w_rem = 20; w_mark = 20; w_next = 20;
         end
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            // ignored mode, not counted
            queue_op(MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST)),
                     ID_W'($urandom), ID_W'($urandom));
         end else begin
            if (roll < 13) begin
               // noise: any operation with raw fields, picks on the bound
               mode = MODE_W'($urandom_range(MODE_INSERT, MODE_PICK));
               id   = ID_W'($urandom);
               pick = $urandom_range(0, 1) ? gen_count[ID_W-1:0] : ID_W'($urandom);
            end else begin
               roll = $urandom_range(0, 99);
               if (roll < w_ins) mode = MODE_INSERT;
               else if (roll < w_ins + w_rem) mode = MODE_REMOVE;
               else if (roll < w_ins + w_rem + w_mark) mode = MODE_MARK;
               else if (roll < w_ins + w_rem + w_mark + w_next) mode = MODE_NEXT;
               else mode = MODE_PICK;
               id   = find_id(mode != MODE_INSERT);
               pick = (gen_count > 0) ? ID_W'($urandom_range(0, gen_count - 1))
                                      : ID_W'($urandom);
            end
            queue_op(mode, id, pick);
            counted++;
         end
      end
      op_total = op_pending.size();

      // synchronous reset, held from time zero
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // every request answered, then a quiet stretch to catch stray responses
      while (rsp_seen < op_total) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (rsp_expected.size() != 0) begin
         $error("%0d responses still outstanding", rsp_expected.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // ---------------------------------------------------------------------
   // request driver: one item held on the port until its transfer, with
   // random idle bursts between items (none in the tail)
   // ---------------------------------------------------------------------
   table_op_type op_current;
   int           idle_left = 0;

   always @(posedge clock) begin
      table_op_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else begin
         // transfer at this edge: the model moves on with the held item
         if (start && !busy) begin
            rsp_expected = {rsp_expected, table_response(op_current)};
         end
         // port is free when nothing is held or the held item just went
         if (!start || !busy) begin
            if (idle_left > 0) begin
               idle_left--;
               start <= 1'b0;
            end else if (op_pending.size() == 0) begin
               start <= 1'b0;
            end else if (op_pending.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
               idle_left = $urandom_range(1, 16) - 1;
               start <= 1'b0;
            end else begin
               nxt = op_pending.pop_front();
               op_current = nxt;
               req_mode       <= nxt.mode;
               req_entry_id   <= nxt.entry_id;
               req_pick_index <= nxt.pick_index;
               start          <= 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // response monitor: a response lives for one cycle only, so it is taken
   // at the edge that ends that cycle and checked against the oldest entry
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      table_rsp_type want;
      if (!reset && rsp_valid) begin
         rsp_seen++;
         if (rsp_expected.size() == 0) begin
            $error("response with no request outstanding: status %0d id %0d",
                   rsp_status, rsp_result_id);
            fail_count++;
         end else begin
            want = rsp_expected.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_result_id !== want.result_id) begin
               $error("result_id: expected %0d, got %0d", want.result_id, rsp_result_id);
               fail_count++;
            end
            if (rsp_entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d", want.entry_count,
                      rsp_entry_count);
               fail_count++;
            end
            if (rsp_tested_count !== want.tested_count) begin
               $error("tested_count: expected %0d, got %0d", want.tested_count,
                      rsp_tested_count);
               fail_count++;
            end
         end
      end
   end

   // hard stop if the block hangs or drops a response
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $error("timeout after %0d cycles, %0d of %0d responses seen",
                cycle_count, rsp_seen, op_total);
         $display("Test completed with failures");
         $finish;
      end
   end

endmodule
